// ===== design/tsd_pkg.sv =====
package tsd_pkg;
  localparam int unsigned PacketBytes = 188;
  localparam logic [7:0] SyncByte = 8'h47;
  localparam logic [7:0] StH264 = 8'h1B;
  localparam logic [7:0] StH265 = 8'h24;
  localparam logic [7:0] StAacA = 8'h0F;
  localparam logic [7:0] StAacB = 8'h11;
  localparam logic [7:0] StLpcm = 8'h80;
  localparam logic [7:0] LastPos = 8'(PacketBytes - 1);
  localparam logic [7:0] PktLen = 8'(PacketBytes);

  typedef enum logic [1:0] {
    CodecH264 = 2'd0,
    CodecH265 = 2'd1,
    CodecAac  = 2'd2,
    CodecLpcm = 2'd3
  } codec_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic       stream_sel;
    logic [7:0] payload_byte;
    logic       unit_start;
    logic [1:0] codec_code;
    logic       packet_last;
  } out_item_t;
endpackage

// ===== design/tsd_front.sv =====
// Front: packet parsing, table learning, PID routing. One byte per cycle while res_ready_i is high.
module tsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsd_pkg::in_item_t  in_data_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output tsd_pkg::out_item_t res_data_o
);
  import tsd_pkg::*;

  logic [7:0]  pos_q, pos_d;
  logic        ok_q, ok_d;
  logic [12:0] pid_q, pid_d;
  logic        us_q, us_d;
  logic [1:0]  ac_q, ac_d;
  logic [7:0]  poff_q, poff_d;
  logic [11:0] slen_q, slen_d;
  logic [39:0] ent_q, ent_d;
  logic [11:0] eend_q, eend_d;
  logic        done_q, done_d;
  logic [8:0]  sst_q, sst_d;
  logic        pmtv_q, pmtv_d, vidv_q, vidv_d, audv_q, audv_d;
  logic [12:0] pmt_q, pmt_d, vid_q, vid_d, aud_q, aud_d;
  logic        hevc_q, hevc_d, lpcm_q, lpcm_d, vst_q, vst_d, ast_q, ast_d;

  logic        acc;
  logic [7:0]  b, pos, k, plen;
  logic [8:0]  j, avail;
  logic [12:0] total, nxt;
  logic [39:0] ent_n;
  logic [11:0] slen_n;
  logic        is_pmt, emit, lst;
  out_item_t   res;

  assign in_ready_o  = res_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign res_valid_o = acc && emit;
  assign res_data_o  = res;
  assign b           = in_data_i.data_byte;
  assign lst         = 1'b0;

  always_comb begin
    pos_d = pos_q; ok_d = ok_q; pid_d = pid_q; us_d = us_q; ac_d = ac_q;
    poff_d = poff_q; slen_d = slen_q; ent_d = ent_q; eend_d = eend_q;
    done_d = done_q; sst_d = sst_q;
    pmtv_d = pmtv_q; pmt_d = pmt_q; vidv_d = vidv_q; vid_d = vid_q;
    audv_d = audv_q; aud_d = aud_q; hevc_d = hevc_q; lpcm_d = lpcm_q;
    vst_d = vst_q; ast_d = ast_q;
    emit = 1'b0; res = '0; is_pmt = 1'b0;
    pos = (pos_q != 8'hFF) ? pos_q + 8'd1 : pos_q;
    k = pos - poff_q;
    plen = PktLen - poff_q;
    j = {1'b0, k} - sst_q;
    avail = {1'b0, plen} - sst_q;
    ent_n = {ent_q[31:0], b};
    slen_n = (j == 9'd2) ? ent_n[11:0] : slen_q;
    total = 13'd3 + {1'b0, slen_n};
    if (total > {4'd0, avail}) total = {4'd0, avail};
    nxt = '0;
    if (in_data_i.action) begin
      vst_d = 1'b0; ast_d = 1'b0; ok_d = 1'b0;
    end else if (in_data_i.packet_start) begin
      pos_d = '0; ok_d = (b == SyncByte);
      pid_d = '0; us_d = 1'b0; ac_d = '0; poff_d = 8'hFF; slen_d = '0;
      ent_d = '0; eend_d = '0; done_d = 1'b0; sst_d = '0;
    end else begin
      pos_d = pos;
      if (!ok_q || pos >= PktLen) ok_d = 1'b0;
      else if (pos == 8'd1) begin
        us_d = b[6]; pid_d = {b[4:0], 8'd0};
      end else if (pos == 8'd2) pid_d = {pid_q[12:8], b};
      else if (pos == 8'd3) begin
        ac_d = b[5:4];
        if (!b[4]) ok_d = 1'b0;
        else poff_d = b[5] ? 8'hFF : 8'd4;
      end else if (pos == 8'd4 && ac_q[1]) begin
        if ({1'b0, b} + 9'd5 >= {1'b0, PktLen}) ok_d = 1'b0;
        else poff_d = b + 8'd5;
      end else if (pos >= poff_q) begin
        // PID 0 is always the PAT, even when the PMT PID is also 0
        is_pmt = pmtv_q && pid_q == pmt_q && pid_q != '0;
        if (pid_q == '0 || is_pmt) begin
          if (!done_q) begin
            if (k == 8'd0) begin
              if ({1'b0, b} + (is_pmt ? 9'd13 : 9'd9) > {1'b0, plen}) done_d = 1'b1;
              else sst_d = {1'b0, b} + 9'd1;
            end else if ({1'b0, k} >= sst_q) begin
              ent_d = ent_n; slen_d = slen_n;
              if (pid_q == '0) begin
                if (j >= 9'd8 && j[1:0] == 2'd3 && {4'd0, j} + 13'd5 <= total
                    && ent_n[31:16] != '0) begin
                  pmtv_d = 1'b1; pmt_d = ent_n[12:0]; done_d = 1'b1;
                end
              end else if (j == 9'd11) begin
                nxt = 13'd12 + {1'b0, ent_n[11:0]};
                eend_d = nxt[12] ? 12'hFFF : nxt[11:0];
              end else if (j >= 9'd12 && {4'd0, j} == {1'b0, eend_q} + 13'd4
                           && {1'b0, eend_q} + 13'd9 <= total) begin
                if ((ent_n[39:32] == StH264 || ent_n[39:32] == StH265) && !vidv_q) begin
                  vidv_d = 1'b1; vid_d = ent_n[28:16]; hevc_d = ent_n[39:32] == StH265;
                end else if ((ent_n[39:32] == StAacA || ent_n[39:32] == StAacB
                              || ent_n[39:32] == StLpcm) && !audv_q) begin
                  audv_d = 1'b1; aud_d = ent_n[28:16]; lpcm_d = ent_n[39:32] == StLpcm;
                end
                nxt = {1'b0, eend_q} + 13'd5 + {1'b0, ent_n[11:0]};
                eend_d = nxt[12] ? 12'hFFF : nxt[11:0];
              end
            end
          end
        end else if (vidv_q && pid_q == vid_q) begin
          emit = vst_q || (k == 8'd0 && us_q);
          vst_d = emit;
          res.stream_sel = 1'b0;
          res.codec_code = hevc_q ? CodecH265 : CodecH264;
        end else if (audv_q && pid_q == aud_q) begin
          emit = ast_q || (k == 8'd0 && us_q);
          ast_d = emit;
          res.stream_sel = 1'b1;
          res.codec_code = lpcm_q ? CodecLpcm : CodecAac;
        end
        res.payload_byte = b;
        res.unit_start = k == 8'd0 && us_q;
        res.packet_last = (pos == LastPos) | lst;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; ok_q <= 1'b0; pid_q <= '0; us_q <= 1'b0; ac_q <= '0;
      poff_q <= '0; slen_q <= '0; ent_q <= '0; eend_q <= '0; done_q <= 1'b0;
      sst_q <= '0; pmtv_q <= 1'b0; pmt_q <= '0; vidv_q <= 1'b0; vid_q <= '0;
      audv_q <= 1'b0; aud_q <= '0; hevc_q <= 1'b0; lpcm_q <= 1'b0;
      vst_q <= 1'b0; ast_q <= 1'b0;
    end else if (acc) begin
      pos_q <= pos_d; ok_q <= ok_d; pid_q <= pid_d; us_q <= us_d; ac_q <= ac_d;
      poff_q <= poff_d; slen_q <= slen_d; ent_q <= ent_d; eend_q <= eend_d;
      done_q <= done_d; sst_q <= sst_d; pmtv_q <= pmtv_d; pmt_q <= pmt_d;
      vidv_q <= vidv_d; vid_q <= vid_d; audv_q <= audv_d; aud_q <= aud_d;
      hevc_q <= hevc_d; lpcm_q <= lpcm_d; vst_q <= vst_d; ast_q <= ast_d;
    end
  end

`ifndef SYNTH
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == res_ready_i) else $error("ready path");
  a_vid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(vidv_q) |-> vidv_q) else $error("video pid lost");
  a_aud_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(audv_q) |-> audv_q) else $error("audio pid lost");
`endif
endmodule

// ===== design/tsd_queue.sv =====
// Two-entry result queue between parser and output port.
module tsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  tsd_pkg::out_item_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output tsd_pkg::out_item_t rd_data_o
);
  import tsd_pkg::*;

  out_item_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("queue ptr");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !rd |=> cnt_q == 2'd2) else $error("queue drop");
`endif
endmodule

// ===== design/ts_packet_pid_demux.sv =====
// Transport stream PID demultiplexer: one byte request per clock, and the result of an
// accepted byte appears in the next cycle at the earliest. The parser is a single stage
// that updates its counters in the accept cycle; a two-entry queue holds results so
// the input keeps flowing while the output is briefly stalled. Input stalls only when
// that queue is full. PAT and PMT are learned on the fly; video/audio payload bytes
// pass once a unit start has been seen on their PID; a reposition request clears that.
module ts_packet_pid_demux (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsd_pkg::out_item_t out_data_o
);
  import tsd_pkg::*;

  logic      res_valid, res_ready;
  out_item_t res_data;

  // front: parse and route
  tsd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_data_o(res_data)
  );

  // back: result queue to output port
  tsd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(res_valid), .wr_ready_o(res_ready), .wr_data_i(res_data),
    .rd_valid_o(out_valid_o), .rd_ready_i(out_ready_i), .rd_data_o(out_data_o)
  );
endmodule

// ===== tb/ts_packet_pid_demux_tb.sv =====
`timescale 1ns / 100ps

module ts_packet_pid_demux_tb;
  import tsd_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  ts_packet_pid_demux u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state; PID registers hold bit 13 = valid, bits 12..0 = PID.
  logic [7:0]  pos_q;
  logic        pkt_ok_q;
  logic [12:0] pid_q;
  logic        pusi_q;
  logic [1:0]  afc_q;
  int unsigned pay_off_q;
  int unsigned sec_len_q, pinfo_len_q, entry_end_q, sec_start_q;
  logic [39:0] sec_bytes_q;
  logic        tbl_done_q;
  logic [13:0] pmt_pid_q, vid_pid_q, aud_pid_q;
  logic        vid_hevc_q, aud_lpcm_q, vid_started_q, aud_started_q;

  out_item_t   pending_payload_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic void model_clear_packet();
    pid_q = '0; pusi_q = 1'b0; afc_q = '0; pay_off_q = 255;
    sec_len_q = 0; pinfo_len_q = 0; sec_bytes_q = '0; entry_end_q = 0;
    tbl_done_q = 1'b0; sec_start_q = 0;
  endfunction

  function automatic void model_reset();
    pos_q = '0; pkt_ok_q = 1'b0;
    model_clear_packet();
    pay_off_q = 0;
    pmt_pid_q = '0; vid_pid_q = '0; aud_pid_q = '0;
    vid_hevc_q = 1'b0; aud_lpcm_q = 1'b0; vid_started_q = 1'b0; aud_started_q = 1'b0;
  endfunction

  function automatic void latch_es_entry();
    logic [7:0]  stype;
    logic [12:0] epid;
    stype = sec_bytes_q[39:32];
    epid = sec_bytes_q[28:16];
    if (stype == StH264 && !vid_pid_q[13]) begin
      vid_pid_q = {1'b1, epid}; vid_hevc_q = 1'b0;
    end else if (stype == StH265 && !vid_pid_q[13]) begin
      vid_pid_q = {1'b1, epid}; vid_hevc_q = 1'b1;
    end else if ((stype == StAacA || stype == StAacB) && !aud_pid_q[13]) begin
      aud_pid_q = {1'b1, epid}; aud_lpcm_q = 1'b0;
    end else if (stype == StLpcm && !aud_pid_q[13]) begin
      aud_pid_q = {1'b1, epid}; aud_lpcm_q = 1'b1;
    end
  endfunction

  // PSI section byte (PAT or PMT); k is the payload index.
  function automatic void parse_table_byte(logic [7:0] b, int unsigned k, int unsigned plen,
                                           bit is_pmt);
    int unsigned j, avail, total, nxt;
    if (tbl_done_q) return;
    if (k == 0) begin
      if (1 + b + (is_pmt ? 12 : 8) > plen) tbl_done_q = 1'b1;
      else sec_start_q = 1 + b;
      return;
    end
    if (k < sec_start_q) return;
    j = k - sec_start_q;
    sec_bytes_q = {sec_bytes_q[31:0], b};
    avail = plen - sec_start_q;
    if (j == 2) sec_len_q = sec_bytes_q[11:0];
    total = 3 + sec_len_q;
    if (total > avail) total = avail;
    if (!is_pmt) begin
      if (j >= 8 && ((j - 8) % 4) == 3 && j + 5 <= total) begin
        if (sec_bytes_q[31:16] != 0) begin
          pmt_pid_q = {1'b1, sec_bytes_q[12:0]};
          tbl_done_q = 1'b1;
        end
      end
      return;
    end
    if (j == 11) begin
      pinfo_len_q = sec_bytes_q[11:0];
      nxt = 12 + pinfo_len_q;
      entry_end_q = nxt > 12'hFFF ? 12'hFFF : nxt;
    end else if (j >= 12 && j == entry_end_q + 4 && entry_end_q + 9 <= total) begin
      latch_es_entry();
      nxt = entry_end_q + 5 + sec_bytes_q[11:0];
      entry_end_q = nxt > 12'hFFF ? 12'hFFF : nxt;
    end
  endfunction

  // Advance the predictor by one request; returns 1 with the routed byte if any.
  function automatic bit demux_predict(in_item_t req, output out_item_t res);
    logic [7:0]  b;
    int unsigned pos, k, plen;
    b = req.data_byte;
    res = '0;
    if (req.action) begin
      vid_started_q = 1'b0; aud_started_q = 1'b0; pkt_ok_q = 1'b0;
      return 0;
    end
    if (req.packet_start) begin
      pos_q = '0;
      pkt_ok_q = (b == SyncByte);
      model_clear_packet();
      return 0;
    end
    if (pos_q != 8'hFF) pos_q++;
    pos = pos_q;
    if (!pkt_ok_q || pos >= PacketBytes) begin
      pkt_ok_q = 1'b0;
      return 0;
    end
    if (pos == 1) begin
      pusi_q = b[6]; pid_q = {b[4:0], 8'h00};
      return 0;
    end
    if (pos == 2) begin
      pid_q[7:0] = b;
      return 0;
    end
    if (pos == 3) begin
      afc_q = b[5:4];
      if (!afc_q[0]) pkt_ok_q = 1'b0;
      else pay_off_q = afc_q[1] ? 255 : 4;
      return 0;
    end
    if (pos == 4 && afc_q[1]) begin
      if (5 + b >= PacketBytes) pkt_ok_q = 1'b0;
      else pay_off_q = 5 + b;
      return 0;
    end
    if (pos < pay_off_q) return 0;
    k = pos - pay_off_q;
    plen = PacketBytes - pay_off_q;
    if (pid_q == 0) begin
      parse_table_byte(b, k, plen, 0);
      return 0;
    end
    if (pmt_pid_q[13] && pid_q == pmt_pid_q[12:0]) begin
      parse_table_byte(b, k, plen, 1);
      return 0;
    end
    if (vid_pid_q[13] && pid_q == vid_pid_q[12:0]) begin
      if (k == 0 && pusi_q) vid_started_q = 1'b1;
      if (!vid_started_q) return 0;
      res.stream_sel = 1'b0;
      res.codec_code = vid_hevc_q ? CodecH265 : CodecH264;
    end else if (aud_pid_q[13] && pid_q == aud_pid_q[12:0]) begin
      if (k == 0 && pusi_q) aud_started_q = 1'b1;
      if (!aud_started_q) return 0;
      res.stream_sel = 1'b1;
      res.codec_code = aud_lpcm_q ? CodecLpcm : CodecAac;
    end else begin
      return 0;
    end
    res.payload_byte = b;
    res.unit_start = (k == 0 && pusi_q);
    res.packet_last = (pos == PacketBytes - 1);
    return 1;
  endfunction

  // Drive one request; valid stays up until accepted. It drops only when the
  // sender idles or when the stimulus stops.
  task automatic send_request(bit act, logic [7:0] b, bit ps);
    in_item_t  req;
    out_item_t res;
    req.action = act; req.data_byte = b; req.packet_start = ps;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (demux_predict(req, res)) pending_payload_q.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_payload_q.size() != 0) @(posedge clk_i);
  endtask

  // Packet builder: header, optional adaptation field, payload bytes.
  byte unsigned pkt_buf[PacketBytes];

  task automatic send_packet(int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++)
      send_request(1'b0, pkt_buf[i], i == 0);
  endtask

  function automatic void fill_header(logic [12:0] pid, bit pusi, logic [1:0] afc,
                                      int unsigned af_len);
    for (int i = 0; i < PacketBytes; i++) pkt_buf[i] = 8'($urandom_range(255));
    pkt_buf[0] = SyncByte;
    pkt_buf[1] = {1'b0, pusi, 1'b0, pid[12:8]};
    pkt_buf[2] = pid[7:0];
    pkt_buf[3] = {2'b00, afc, 4'($urandom_range(15))};
    if (afc[1]) pkt_buf[4] = 8'(af_len);
  endfunction

  // Payload start index for a header built above.
  function automatic int unsigned pay_start(logic [1:0] afc, int unsigned af_len);
    return afc[1] ? 5 + af_len : 4;
  endfunction

  function automatic void build_pat(logic [12:0] pmt_pid, int unsigned ptr,
                                    int unsigned zero_progs);
    int unsigned p;
    fill_header(13'd0, 1'b1, 2'b01, 0);
    p = 4;
    pkt_buf[p++] = 8'(ptr);
    p += ptr;
    pkt_buf[p++] = 8'h00;
    pkt_buf[p++] = 8'hB0;
    pkt_buf[p++] = 8'(13 + 4 * zero_progs);
    p += 5;
    for (int unsigned z = 0; z < zero_progs; z++) begin
      pkt_buf[p++] = 8'h00; pkt_buf[p++] = 8'h00;
      pkt_buf[p++] = 8'hE0; pkt_buf[p++] = 8'h10;
    end
    pkt_buf[p++] = 8'h00; pkt_buf[p++] = 8'h01;
    pkt_buf[p++] = {3'b111, pmt_pid[12:8]}; pkt_buf[p++] = pmt_pid[7:0];
  endfunction

  // PMT with up to 4 entries; info_len bytes of program descriptors.
  function automatic void build_pmt(logic [12:0] pmt_pid, logic [7:0] st[4],
                                    logic [12:0] es[4], int unsigned n,
                                    int unsigned info_len);
    int unsigned p;
    fill_header(pmt_pid, 1'b1, 2'b01, 0);
    p = 4;
    pkt_buf[p++] = 0;
    pkt_buf[p++] = 8'h02;
    pkt_buf[p++] = 8'hB0;
    pkt_buf[p++] = 8'(13 + info_len + 5 * n);
    p += 7;
    pkt_buf[p++] = {6'b111100, 2'(info_len >> 8)};
    pkt_buf[p++] = 8'(info_len);
    p += info_len;
    for (int unsigned e = 0; e < n; e++) begin
      pkt_buf[p++] = st[e];
      pkt_buf[p++] = {3'b111, es[e][12:8]};
      pkt_buf[p++] = es[e][7:0];
      pkt_buf[p++] = 8'hF0;
      pkt_buf[p++] = 8'h00;
    end
  endfunction

  // Header plus a short run of payload; a long adaptation field gives a full packet.
  task automatic send_es(logic [12:0] pid, bit pusi, logic [1:0] afc, int unsigned af_len);
    int unsigned nbytes;
    fill_header(pid, pusi, afc, af_len);
    nbytes = pay_start(afc, af_len) + 24;
    send_packet(nbytes > PacketBytes ? PacketBytes : nbytes);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver backpressure.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_payload_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          out_item_t exp_res;
          exp_res = pending_payload_q.pop_front();
          if (out_data_o.stream_sel !== exp_res.stream_sel ||
              out_data_o.payload_byte !== exp_res.payload_byte ||
              out_data_o.unit_start !== exp_res.unit_start ||
              out_data_o.codec_code !== exp_res.codec_code ||
              out_data_o.packet_last !== exp_res.packet_last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected %p, got %p", exp_res, out_data_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  logic [7:0]  st_tbl[4];
  logic [12:0] es_tbl[4];

  // Directed: PAT, PMT with H.264 + AAC, stray bytes, extremes.
  task automatic test_directed_basic();
    for (int i = 0; i < 3; i++) send_request(1'b0, 8'hFF, 1'b0);  // no packet yet
    build_pat(13'h0100, 0, 1);
    send_packet(24);
    st_tbl = '{StH264, StAacA, StH265, StLpcm};
    es_tbl = '{13'h0101, 13'h1FFF, 13'h0103, 13'h0104};
    build_pmt(13'h0100, st_tbl, es_tbl, 4, 3);
    send_packet(44);
    send_es(13'h0101, 1'b0, 2'b01, 0);         // not started yet
    send_es(13'h0101, 1'b1, 2'b11, 0);
    send_es(13'h1FFF, 1'b1, 2'b11, 181);      // long adaptation field
    fill_header(13'h1FFF, 1'b0, 2'b11, 182);  // longest legal adaptation field
    send_packet(8);
    send_es(13'h0101, 1'b0, 2'b10, 0);        // no payload
    fill_header(13'h0101, 1'b0, 2'b01, 0);
    pkt_buf[0] = 8'h48;                        // bad sync
    send_packet(28);
    fill_header(13'h0101, 1'b0, 2'b01, 0);
    send_packet(PacketBytes);
    for (int i = 0; i < 4; i++) send_request(1'b0, 8'(i * 85), 1'b0);  // past the end
    send_request(1'b1, 8'hAA, 1'b0);           // reposition
    send_es(13'h0101, 1'b0, 2'b01, 0);         // blocked after reposition
    send_es(13'h0101, 1'b1, 2'b01, 0);
  endtask

  // PID collisions, table too short, repeated PAT.
  task automatic test_special_tables();
    build_pat(13'h0101, 0, 0);                 // PMT PID now collides with video
    send_packet(20);
    send_es(13'h0101, 1'b1, 2'b01, 0);         // parsed as PMT, no output
    build_pat(13'h0100, 180, 0);               // header not in packet
    send_packet(8);
    build_pat(13'h0100, 0, 40);                // long section of empty programs
    send_packet(180);
    build_pat(13'h0100, 0, 0);
    send_packet(20);
    send_es(13'h1FFF, 1'b1, 2'b01, 0);
    wait_drained();                            // sender holds off until all results are in
  endtask

  // Random: mostly well-formed packets on the known PIDs, plus noise.
  task automatic test_random_stream(int unsigned n_bytes);
    int unsigned sent;
    logic [12:0] pids[5];
    sent = 0;
    pids = '{13'h0000, 13'h0100, 13'h0101, 13'h1FFF, 13'($urandom_range(8191))};
    while (sent < n_bytes) begin
      int unsigned sel, len, af;
      logic [1:0] afc;
      sel = $urandom_range(99);
      if (sel < 4) begin
        send_request(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else if (sel < 10) begin
        send_request(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else begin
        afc = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1) ? 3 : 1);
        af = ($urandom_range(7) == 0) ? $urandom_range(187) : $urandom_range(20);
        fill_header(pids[$urandom_range(4)], 1'($urandom_range(1)), afc, af);
        if ($urandom_range(19) == 0) pkt_buf[0] = 8'($urandom_range(255));
        // short packets mostly, so the random part holds many headers
        len = ($urandom_range(3) == 0) ? PacketBytes + $urandom_range(3)
                                        : pay_start(afc, af) + $urandom_range(20);
        if (len > PacketBytes) begin
          send_packet(PacketBytes);
          for (int unsigned x = PacketBytes; x < len; x++)
            send_request(1'b0, 8'($urandom_range(255)), 1'b0);
        end else begin
          send_packet(len);
        end
        sent += len;
      end
    end
  endtask

  // Program map with H.265 and LPCM; only a stream kind not yet latched takes its entry.
  task automatic test_relearn_codecs();
    st_tbl = '{StH265, StLpcm, StAacB, StH264};
    es_tbl = '{13'h0201, 13'h0202, 13'h0203, 13'h0204};
    build_pat(13'h0200, 2, 0);
    send_packet(24);
    build_pmt(13'h0200, st_tbl, es_tbl, 4, 0);
    send_packet(40);
    send_es(13'h0201, 1'b1, 2'b01, 0);
    send_es(13'h0202, 1'b1, 2'b01, 0);
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26; recv_idle_pct = 51;
    test_directed_basic();
    test_special_tables();
    test_random_stream(100);
    send_idle_pct = 51; recv_idle_pct = 26;
    test_random_stream(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_stream(100);

    // Separate simulation state: a fresh predictor needs a fresh block, so the
    // codec relearn runs on the latched map only where its streams are free.
    if (!vid_pid_q[13] || !aud_pid_q[13]) test_relearn_codecs();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_payload_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
